/* src/pwdh_pkg.sv */
`default_nettype none

package pwdh_pkg;

	localparam int unsigned GRID_MAX_DEF = 64;
	localparam int unsigned OP_W         = 2;
	localparam int unsigned POS_W        = 32;
	localparam int unsigned INV_W        = 32;
	localparam int unsigned WEIGHT_W     = 16;
	localparam int unsigned IDX_W        = 18;
	localparam int unsigned COUNT_W      = 32;
	localparam int unsigned GRID_W       = 7;
	localparam int unsigned CFG_IDX_W    = 1;
	localparam int unsigned CFG_DATA_W   = 32;
	localparam int unsigned FRAC_W       = 48;
	localparam int unsigned AXES         = 3;

	localparam logic [GRID_W-1:0]  GRID_DIVS_RST = 7'd64;
	localparam logic [INV_W-1:0]   INV_BOX_RST   = '1;
	localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;

	typedef enum logic [OP_W-1:0] {
		OP_ACCUM = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_DIVS   = 1'b0,
		REG_INV_BOX_LEN = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic                valid;
		op_t                 op;
		logic [WEIGHT_W-1:0] weight;
		logic                new_walker;
		logic                beyond;
	} item_ctl_t;

endpackage

`default_nettype wire

/* src/pwdh_if.sv */
`default_nettype none

interface pwdh_item_if import pwdh_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic [OP_W-1:0]            op;
	logic signed [POS_W-1:0]    pos_x;
	logic signed [POS_W-1:0]    pos_y;
	logic signed [POS_W-1:0]    pos_z;
	logic [WEIGHT_W-1:0]        walker_weight;
	logic                       new_walker;
	logic [IDX_W-1:0]           bin_index;

	modport source (
		output valid, op, pos_x, pos_y, pos_z, walker_weight, new_walker, bin_index,
		input  ready
	);
	modport sink (
		input  valid, op, pos_x, pos_y, pos_z, walker_weight, new_walker, bin_index,
		output ready
	);
endinterface

interface pwdh_result_if import pwdh_pkg::*;;
	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] bin_count;
	logic [COUNT_W-1:0] total_weight;

	modport source (
		output valid, bin_count, total_weight,
		input  ready
	);
	modport sink (
		input  valid, bin_count, total_weight,
		output ready
	);
endinterface

`default_nettype wire

/* src/pwdh_ram.sv */
`default_nettype none

module pwdh_ram import pwdh_pkg::*; #(
	parameter int unsigned WIDTH = COUNT_W,
	parameter int unsigned DEPTH = GRID_MAX_DEF * GRID_MAX_DEF * GRID_MAX_DEF,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* src/pwdh_cfg.sv */
`default_nettype none

module pwdh_cfg import pwdh_pkg::*; #(
	parameter int unsigned GRID_MAX = GRID_MAX_DEF,
	localparam int unsigned GSIZE_W = $clog2(GRID_MAX + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic [GSIZE_W-1:0]    grid,
	output logic [INV_W-1:0]      inv_len
);

	logic [GSIZE_W-1:0] grid_q;
	logic [INV_W-1:0]   inv_q;

	// The grid size is held already clamped to the range the bin store supports.
	function automatic logic [GSIZE_W-1:0] grid_clamp(input logic [GRID_W-1:0] v);
		logic [GSIZE_W-1:0] g;
		if (v == '0) begin
			g = GSIZE_W'(1);
		end else if (32'(v) > GRID_MAX) begin
			g = GSIZE_W'(GRID_MAX);
		end else begin
			g = GSIZE_W'(v);
		end
		return g;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q <= grid_clamp(GRID_DIVS_RST);
			inv_q  <= INV_BOX_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_GRID_DIVS: begin
					grid_q <= grid_clamp(cfg_data[GRID_W-1:0]);
				end
				REG_INV_BOX_LEN: begin
					inv_q <= cfg_data[INV_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign grid    = grid_q;
	assign inv_len = inv_q;

endmodule

`default_nettype wire

/* src/pwdh_bin_calc.sv */
`default_nettype none

module pwdh_bin_calc import pwdh_pkg::*; #(
	parameter int unsigned GRID_MAX = GRID_MAX_DEF,
	localparam int unsigned ADDR_W  = $clog2(GRID_MAX * GRID_MAX * GRID_MAX),
	localparam int unsigned GSIZE_W = $clog2(GRID_MAX + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    advance,
	input  logic                    take,
	input  logic [OP_W-1:0]         op,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic signed [POS_W-1:0] pos_z,
	input  logic [WEIGHT_W-1:0]     weight,
	input  logic                    new_walker,
	input  logic [IDX_W-1:0]        bin_index,
	input  logic [GSIZE_W-1:0]      grid,
	input  logic [INV_W-1:0]        inv_len,
	output item_ctl_t               ctl_s4,
	output logic [ADDR_W-1:0]       addr_s4
);

	localparam int unsigned BIN_STORE = GRID_MAX * GRID_MAX * GRID_MAX;
	localparam int unsigned BIN_W     = $clog2(GRID_MAX);
	localparam int unsigned PLANE_W   = $clog2(GRID_MAX * GRID_MAX);
	localparam int unsigned PG_W      = FRAC_W + GSIZE_W;

	item_ctl_t ctl_s1, ctl_s2, ctl_s3;

	logic signed [POS_W-1:0]   pos_s1 [AXES];
	logic [FRAC_W-1:0]         frac_s2 [AXES];
	logic [BIN_W-1:0]          bin_s3 [AXES];
	logic [ADDR_W-1:0]         idx_s1, idx_s2, idx_s3, idx_s4;
	logic [PLANE_W-1:0]        plane_s4;
	logic [BIN_W-1:0]          col_s4;
	logic [31:0]               idx_wide;
	logic signed [2*POS_W:0]   prod [AXES];
	logic [PG_W-1:0]           scaled [AXES];
	logic [ADDR_W-1:0]         flat;

	assign idx_wide = 32'(bin_index);

	// Position times inverse length; the low bits of the product are the wrapped fraction.
	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			prod[i]   = pos_s1[i] * $signed({1'b0, inv_len});
			scaled[i] = PG_W'(frac_s2[i]) * PG_W'(grid);
		end
	end

	assign flat    = ADDR_W'(ADDR_W'(plane_s4) * ADDR_W'(grid) + ADDR_W'(col_s4));
	assign addr_s4 = (ctl_s4.op == OP_READ) ? idx_s4 : flat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else if (advance) begin
			ctl_s1 <= '{valid: take, op: op_t'(op), weight: weight,
				new_walker: new_walker, beyond: (idx_wide >= 32'(BIN_STORE))};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pos_s1[0] <= pos_x;
			pos_s1[1] <= pos_y;
			pos_s1[2] <= pos_z;
			idx_s1    <= idx_wide[ADDR_W-1:0];
			idx_s2    <= idx_s1;
			idx_s3    <= idx_s2;
			idx_s4    <= idx_s3;
			for (int i = 0; i < AXES; i++) begin
				frac_s2[i] <= prod[i][FRAC_W-1:0];
				bin_s3[i]  <= scaled[i][FRAC_W +: BIN_W];
			end
			plane_s4 <= PLANE_W'(PLANE_W'(bin_s3[0]) * PLANE_W'(grid) + PLANE_W'(bin_s3[1]));
			col_s4   <= bin_s3[2];
		end
	end

endmodule

`default_nettype wire

/* src/pwdh_accum.sv */
`default_nettype none

module pwdh_accum import pwdh_pkg::*; #(
	parameter int unsigned GRID_MAX = GRID_MAX_DEF,
	localparam int unsigned ADDR_W  = $clog2(GRID_MAX * GRID_MAX * GRID_MAX)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               clear_taken,
	input  item_ctl_t          ctl_s4,
	input  logic [ADDR_W-1:0]  addr_s4,
	input  logic               out_ready,
	output logic               advance,
	output logic               accepting,
	output logic               out_valid,
	output logic [COUNT_W-1:0] bin_count,
	output logic [COUNT_W-1:0] total_weight
);

	localparam int unsigned BIN_STORE = GRID_MAX * GRID_MAX * GRID_MAX;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BIN_STORE - 1);

	typedef enum logic [2:0] {
		ST_RUN   = 3'b001,
		ST_DRAIN = 3'b010,
		ST_SWEEP = 3'b100
	} state_t;

	state_t             state_q;
	item_ctl_t          ctl_s5;
	logic [ADDR_W-1:0]  addr_s5, sweep_q, fw_addr_q, ram_waddr;
	logic [COUNT_W-1:0] rd_data, cur, upd, fw_data_q, total_q, bin_q, tot_out_q, ram_wdata;
	logic [COUNT_W:0]   sum, tsum;
	logic               fw_valid_q, out_valid_q, sweeping, do_read, do_wr, add_total;
	logic               ram_we, clear_at_s5;

	assign sweeping    = (state_q == ST_SWEEP);
	assign accepting   = (state_q == ST_RUN);
	assign do_read     = ctl_s5.valid && (ctl_s5.op == OP_READ);
	assign clear_at_s5 = ctl_s5.valid && (ctl_s5.op == OP_CLEAR);
	assign advance     = !(do_read && out_valid_q && !out_ready);

	// The write made in the cycle of this entry's read is not in the read data.
	assign cur  = (fw_valid_q && (fw_addr_q == addr_s5)) ? fw_data_q : rd_data;
	assign sum  = {1'b0, cur} + (COUNT_W + 1)'(ctl_s5.weight);
	assign upd  = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
	assign tsum = {1'b0, total_q} + (COUNT_W + 1)'(ctl_s5.weight);

	assign do_wr     = advance && ctl_s5.valid && (ctl_s5.op == OP_ACCUM) && (ctl_s5.weight != '0);
	assign add_total = do_wr && ctl_s5.new_walker;

	assign ram_we    = sweeping || do_wr;
	assign ram_waddr = sweeping ? sweep_q : addr_s5;
	assign ram_wdata = sweeping ? '0 : upd;

	pwdh_ram #(
		.WIDTH(COUNT_W),
		.DEPTH(BIN_STORE)
	) u_bins (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (advance),
		.raddr(addr_s4),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			sweep_q     <= '0;
			ctl_s5      <= '0;
			fw_valid_q  <= 1'b0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				ctl_s5 <= ctl_s4;
			end
			case (state_q)
				ST_RUN: begin
					if (clear_taken) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (clear_at_s5) begin
						state_q <= ST_SWEEP;
						sweep_q <= '0;
					end
				end
				ST_SWEEP: begin
					sweep_q <= sweep_q + ADDR_W'(1);
					if (sweep_q == LAST_ADDR) begin
						state_q <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_SWEEP;
					sweep_q <= '0;
				end
			endcase
			if ((state_q == ST_DRAIN) && clear_at_s5) begin
				total_q <= '0;
			end else if (add_total) begin
				total_q <= tsum[COUNT_W] ? COUNT_MAX : tsum[COUNT_W-1:0];
			end
			if (sweeping) begin
				fw_valid_q <= 1'b0;
			end else if (do_wr) begin
				fw_valid_q <= 1'b1;
			end
			if (advance && do_read) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			addr_s5 <= addr_s4;
		end
		if (do_wr) begin
			fw_addr_q <= addr_s5;
			fw_data_q <= upd;
		end
		if (advance && do_read) begin
			bin_q     <= ctl_s5.beyond ? '0 : cur;
			tot_out_q <= total_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign bin_count    = bin_q;
	assign total_weight = tot_out_q;

endmodule

`default_nettype wire

/* src/periodic_weighted_density_histogram.sv */
// Weighted 3D density histogram over a periodic cubic cell, GRID_MAX^3 bins of 32 bits held in
// one synchronous memory. The block takes one item per clock in steady state: accumulate items
// stream through four stages of binning arithmetic and then a read-modify-write of the bin
// memory, one bin per cycle, with the previous write forwarded to the next read. A read
// returns its result from an output register, and stalls the stream only while a
// result is still waiting to be taken. After reset, and after each clear, the block sweeps
// the whole bin memory, one bin a cycle, and accepts no item meanwhile; a clear first lets
// the items ahead of it finish. Configuration writes are taken at any time but are meant
// for an idle block.
`default_nettype none

module periodic_weighted_density_histogram import pwdh_pkg::*; #(
	parameter int unsigned GRID_MAX = GRID_MAX_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	pwdh_item_if.sink             item,
	pwdh_result_if.source         result
);

	localparam int unsigned ADDR_W  = $clog2(GRID_MAX * GRID_MAX * GRID_MAX);
	localparam int unsigned GSIZE_W = $clog2(GRID_MAX + 1);

	logic [GSIZE_W-1:0] grid;
	logic [INV_W-1:0]   inv_len;
	logic               advance, accepting, take, clear_taken;
	item_ctl_t          ctl_s4;
	logic [ADDR_W-1:0]  addr_s4;

	assign item.ready  = accepting && advance;
	assign take        = item.valid && item.ready;
	assign clear_taken = take && (op_t'(item.op) == OP_CLEAR);

	pwdh_cfg #(
		.GRID_MAX(GRID_MAX)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.grid     (grid),
		.inv_len  (inv_len)
	);

	pwdh_bin_calc #(
		.GRID_MAX(GRID_MAX)
	) u_bin_calc (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.take      (take),
		.op        (item.op),
		.pos_x     (item.pos_x),
		.pos_y     (item.pos_y),
		.pos_z     (item.pos_z),
		.weight    (item.walker_weight),
		.new_walker(item.new_walker),
		.bin_index (item.bin_index),
		.grid      (grid),
		.inv_len   (inv_len),
		.ctl_s4    (ctl_s4),
		.addr_s4   (addr_s4)
	);

	pwdh_accum #(
		.GRID_MAX(GRID_MAX)
	) u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.clear_taken (clear_taken),
		.ctl_s4      (ctl_s4),
		.addr_s4     (addr_s4),
		.out_ready   (result.ready),
		.advance     (advance),
		.accepting   (accepting),
		.out_valid   (result.valid),
		.bin_count   (result.bin_count),
		.total_weight(result.total_weight)
	);

endmodule

`default_nettype wire
